// ----- rtl/core/stunbr_pkg.sv -----
// Shared types, constants and helpers for the STUN binding response parser.
// No dependencies; used by stunbr_walk and stun_binding_response_parser_unit.
package stunbr_pkg;

	localparam int unsigned MAX_PACKET_DEFAULT = 256;
	localparam int unsigned HDR_SIZE = 20;
	localparam int unsigned ADDR_ATTR_LEN = 8;
	// Header, attribute type, attribute length and a full address value.
	localparam int unsigned MIN_FOUND_POS = HDR_SIZE + 4 + ADDR_ATTR_LEN;

	localparam logic [15:0] MSG_TYPE = 16'h0101;
	localparam logic [31:0] MAGIC_COOKIE = 32'h2112A442;
	localparam logic [15:0] ATTR_MAPPED = 16'h0001;
	localparam logic [15:0] ATTR_XOR_MAPPED = 16'h0020;

	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 64;
	localparam logic [CFG_IDX_W-1:0] REG_TID_FIRST = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TID_LAST = 1'b1;

	typedef enum logic [2:0] {
		ST_OK,
		ST_TOO_SHORT,
		ST_BAD_TYPE,
		ST_BAD_COOKIE,
		ST_BAD_TID,
		ST_NO_ADDR
	} status_t;

	typedef enum logic [2:0] {
		PH_TYPE,
		PH_LEN,
		PH_VALUE,
		PH_SKIP,
		PH_FOUND,
		PH_FAIL
	} phase_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] mapped_address;
		logic        was_xor_mapped;
	} result_t;

	// Expected value of header byte pos; bytes 2 and 3 are never compared.
	function automatic logic [7:0] hdr_byte(input logic [4:0] pos, input logic [31:0] tid_first,
		input logic [63:0] tid_last);
		logic [159:0] hdr;
		logic [4:0]   idx;
		hdr = {MSG_TYPE, 16'h0000, MAGIC_COOKIE, tid_first, tid_last};
		idx = 5'(HDR_SIZE - 1) - pos;
		if (pos >= 5'(HDR_SIZE)) begin
			return 8'h00;
		end
		return hdr[{idx, 3'b000} +: 8];
	endfunction

endpackage

// ----- rtl/core/stun_binding_response_parser_unit.sv -----
// Top level of the STUN binding response parser: ports, config registers, input and result
// registers. Depends on stunbr_pkg and stunbr_walk.
//
// The block takes one datagram byte per cycle unless byte_stall is high, with no gaps required
// between bytes or datagrams, and emits one result transaction for each byte marked last:
// status, mapped_address and was_xor_mapped. A byte passes through the input register and is
// then folded into the datagram state; when the final byte of a datagram is folded in, its
// result is loaded into the result register. The input register and the result register let
// a new byte enter while a finished result still waits; the byte channel stalls only when a
// second final byte is ready while the result register is full and stalled. Bytes at positions
// MAX_PACKET and beyond are ignored apart from their last mark. Configuration writes take effect
// at once and must be made between datagrams by the user; the block does not enforce this.
module stun_binding_response_parser_unit #(
	parameter int unsigned MAX_PACKET = stunbr_pkg::MAX_PACKET_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [stunbr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [stunbr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                              byte_valid,
	output logic                              byte_stall,
	input  logic [7:0]                        data_byte,
	input  logic                              last_byte,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [2:0]                        status,
	output logic [31:0]                       mapped_address,
	output logic                              was_xor_mapped
);

	logic [31:0]         tid_first_q;
	logic [63:0]         tid_last_q;
	logic                byte_valid_s1;
	logic [7:0]          data_s1;
	logic                last_s1;
	logic                step;
	logic                result_valid_q;
	stunbr_pkg::result_t walk_result;
	stunbr_pkg::result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tid_first_q <= 32'h0;
			tid_last_q <= 64'h0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				stunbr_pkg::REG_TID_FIRST: tid_first_q <= cfg_wdata[31:0];
				stunbr_pkg::REG_TID_LAST: tid_last_q <= cfg_wdata[63:0];
				default: tid_first_q <= tid_first_q;
			endcase
		end
	end

	assign step = byte_valid_s1 && (!last_s1 || !result_valid_q || !result_stall);
	assign byte_stall = byte_valid_s1 && !step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			byte_valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	stunbr_walk #(
		.MAX_PACKET(MAX_PACKET)
	) u_walk (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.data_byte(data_s1),
		.last_byte(last_s1),
		.tid_first(tid_first_q),
		.tid_last(tid_last_q),
		.result(walk_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			result_q <= walk_result;
		end
	end

	assign result_valid = result_valid_q;
	assign status = result_q.status;
	assign mapped_address = result_q.mapped_address;
	assign was_xor_mapped = result_q.was_xor_mapped;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> byte_valid_s1 && last_s1 && result_valid_q && result_stall)
		else $error("Byte channel stalled without a blocked result.");

	a_addr_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != stunbr_pkg::ST_OK |-> mapped_address == 32'h0 && !was_xor_mapped)
		else $error("Address reported with a failing status.");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> status <= 3'(stunbr_pkg::ST_NO_ADDR))
		else $error("Result status out of range.");

	a_result_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_s1 |=> result_valid)
		else $error("Final byte processed without a result transaction.");

endmodule

// ----- rtl/core/stunbr_walk.sv -----
// Per-datagram state: header checks, attribute walk and address capture.
// Depends on stunbr_pkg; the result for the current byte is combinational.
module stunbr_walk #(
	parameter int unsigned MAX_PACKET = stunbr_pkg::MAX_PACKET_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	input  logic [31:0]          tid_first,
	input  logic [63:0]          tid_last,
	output stunbr_pkg::result_t  result
);

	localparam int unsigned POS_W = $clog2(MAX_PACKET + 1);

	logic [POS_W-1:0]   pos_q, pos_d;
	stunbr_pkg::status_t hdr_err_q, hdr_err_d;
	stunbr_pkg::phase_t phase_q, phase_d;
	logic               fidx_q, fidx_d;
	logic [15:0]        atype_q, atype_d;
	logic [15:0]        alen_q, alen_d;
	logic [16:0]        skip_q, skip_d;
	logic [31:0]        addr_q, addr_d;
	logic               xor_q, xor_d;

	logic               in_range, in_hdr, in_body, is_addr_attr;
	logic [16:0]        skip_pad;
	stunbr_pkg::status_t status_d;

	assign in_range = pos_q < POS_W'(MAX_PACKET);
	assign in_hdr = in_range && (pos_q < POS_W'(stunbr_pkg::HDR_SIZE));
	assign in_body = in_range && !in_hdr;
	assign alen_d = (in_body && phase_q == stunbr_pkg::PH_LEN) ? {alen_q[7:0], data_byte} : alen_q;
	assign is_addr_attr = (atype_q == stunbr_pkg::ATTR_MAPPED)
		|| (atype_q == stunbr_pkg::ATTR_XOR_MAPPED);
	assign skip_pad = (17'(alen_d) + 17'd3) & 17'h1FFFC;
	assign pos_d = in_range ? pos_q + POS_W'(1) : pos_q;

	always_comb begin
		phase_d = phase_q;
		if (in_body) begin
			case (phase_q)
				stunbr_pkg::PH_TYPE: begin
					if (fidx_q) begin
						phase_d = stunbr_pkg::PH_LEN;
					end
				end
				stunbr_pkg::PH_LEN: begin
					if (fidx_q) begin
						if (is_addr_attr) begin
							phase_d = (alen_d == 16'(stunbr_pkg::ADDR_ATTR_LEN))
								? stunbr_pkg::PH_VALUE : stunbr_pkg::PH_FAIL;
						end else begin
							phase_d = (skip_pad == 17'd0) ? stunbr_pkg::PH_TYPE
								: stunbr_pkg::PH_SKIP;
						end
					end
				end
				stunbr_pkg::PH_VALUE: begin
					if (skip_q == 17'd1) begin
						phase_d = stunbr_pkg::PH_FOUND;
					end
				end
				stunbr_pkg::PH_SKIP: begin
					if (skip_q == 17'd1) begin
						phase_d = stunbr_pkg::PH_TYPE;
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	always_comb begin
		hdr_err_d = hdr_err_q;
		fidx_d = fidx_q;
		atype_d = atype_q;
		skip_d = skip_q;
		addr_d = addr_q;
		xor_d = xor_q;
		if (in_hdr && pos_q != POS_W'(2) && pos_q != POS_W'(3)
			&& hdr_err_q == stunbr_pkg::ST_OK
			&& data_byte != stunbr_pkg::hdr_byte(pos_q[4:0], tid_first, tid_last)) begin
			if (pos_q < POS_W'(2)) begin
				hdr_err_d = stunbr_pkg::ST_BAD_TYPE;
			end else if (pos_q < POS_W'(8)) begin
				hdr_err_d = stunbr_pkg::ST_BAD_COOKIE;
			end else begin
				hdr_err_d = stunbr_pkg::ST_BAD_TID;
			end
		end
		if (in_body) begin
			case (phase_q)
				stunbr_pkg::PH_TYPE: begin
					atype_d = {atype_q[7:0], data_byte};
					fidx_d = !fidx_q;
				end
				stunbr_pkg::PH_LEN: begin
					fidx_d = !fidx_q;
					if (fidx_q) begin
						if (is_addr_attr) begin
							xor_d = atype_q == stunbr_pkg::ATTR_XOR_MAPPED;
							addr_d = 32'h0;
							skip_d = 17'(stunbr_pkg::ADDR_ATTR_LEN);
						end else begin
							skip_d = skip_pad;
						end
					end
				end
				stunbr_pkg::PH_VALUE: begin
					if (skip_q <= 17'd4) begin
						addr_d = {addr_q[23:0], data_byte};
					end
					skip_d = skip_q - 17'd1;
				end
				stunbr_pkg::PH_SKIP: begin
					skip_d = skip_q - 17'd1;
				end
				default: begin
					skip_d = skip_q;
				end
			endcase
		end
	end

	always_comb begin
		if (pos_d < POS_W'(stunbr_pkg::HDR_SIZE)) begin
			status_d = stunbr_pkg::ST_TOO_SHORT;
		end else if (hdr_err_d != stunbr_pkg::ST_OK) begin
			status_d = hdr_err_d;
		end else if (phase_d == stunbr_pkg::PH_FOUND) begin
			status_d = stunbr_pkg::ST_OK;
		end else begin
			status_d = stunbr_pkg::ST_NO_ADDR;
		end
		result.status = status_d;
		result.mapped_address = 32'h0;
		result.was_xor_mapped = 1'b0;
		if (status_d == stunbr_pkg::ST_OK) begin
			result.mapped_address = xor_d ? (addr_d ^ stunbr_pkg::MAGIC_COOKIE) : addr_d;
			result.was_xor_mapped = xor_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			hdr_err_q <= stunbr_pkg::ST_OK;
			phase_q <= stunbr_pkg::PH_TYPE;
			fidx_q <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				pos_q <= '0;
				hdr_err_q <= stunbr_pkg::ST_OK;
				phase_q <= stunbr_pkg::PH_TYPE;
				fidx_q <= 1'b0;
			end else begin
				pos_q <= pos_d;
				hdr_err_q <= hdr_err_d;
				phase_q <= phase_d;
				fidx_q <= fidx_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			atype_q <= atype_d;
			alen_q <= alen_d;
			skip_q <= skip_d;
			addr_q <= addr_d;
			xor_q <= xor_d;
		end
	end

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(pos_q) <= int'(MAX_PACKET))
		else $error("Byte position passed the packet limit.");

	a_found_needs_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == stunbr_pkg::PH_FOUND |-> int'(pos_q) >= int'(stunbr_pkg::MIN_FOUND_POS))
		else $error("Address found before enough bytes were seen.");

	a_fidx_phase: assert property (@(posedge clk) disable iff (!arst_n)
		fidx_q |-> (phase_q == stunbr_pkg::PH_TYPE || phase_q == stunbr_pkg::PH_LEN))
		else $error("Field byte index set outside type or length phase.");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_byte |=> pos_q == '0 && phase_q == stunbr_pkg::PH_TYPE)
		else $error("Datagram state not cleared after the final byte.");

endmodule
